/* hw/rtl/stack_machine_execute_unit_defines.svh */
// assertion macros for the stack machine execute unit checker
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, checked at every clock edge outside reset
`define SME_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sme_pkg.sv */
// types and constants shared by the stack machine execute unit
`default_nettype none
package sme_pkg;
	localparam int WORD_W       = 32;
	localparam int NEXT_W       = 12;
	localparam int CHECK_W      = 34;
	localparam int HEADER_WORDS = 4;
	localparam int HDR_LOCALS   = 3;
	localparam int HDR_PARAMS   = 2;
	localparam int HDR_SAVED_FP = 1;
	localparam logic [7:0] LIMIT_RESET = 8'd20;
	localparam logic [5:0] KIND_LAST   = 6'd33;

	typedef enum logic [5:0] {
		OP_HALT = 6'd0, OP_ADD = 6'd1, OP_SUB = 6'd2, OP_MUL = 6'd3, OP_DIV = 6'd4,
		OP_MOD = 6'd5, OP_NEG = 6'd6, OP_AND = 6'd7, OP_OR = 6'd8, OP_NOT = 6'd9,
		OP_LT = 6'd10, OP_GT = 6'd11, OP_EQ = 6'd12, OP_LEQ = 6'd13, OP_GEQ = 6'd14,
		OP_NEQ = 6'd15, OP_PUSH = 6'd16, OP_POP = 6'd17, OP_SWAP = 6'd18,
		OP_DUP = 6'd19, OP_GET_GLOBAL = 6'd20, OP_SET_GLOBAL = 6'd21,
		OP_JUMP = 6'd22, OP_JUMP_POS = 6'd23, OP_JUMP_ZERO = 6'd24,
		OP_GET_LOCAL = 6'd25, OP_SET_LOCAL = 6'd26, OP_GET_PARAM = 6'd27,
		OP_SAVE = 6'd28, OP_FRAME = 6'd29, OP_CALL = 6'd30, OP_RET_VALUE = 6'd31,
		OP_RETURN = 6'd32, OP_SAY = 6'd33, OP_ILLEGAL = 6'd63
	} op_t;

	typedef enum logic [2:0] {
		ST_RUN = 3'd0, ST_HALT = 3'd1, ST_OVERFLOW = 3'd2, ST_DIVZERO = 3'd3,
		ST_ILLEGAL = 3'd4, ST_FRAME = 3'd5
	} status_t;

	// per-instruction class flags set by the front end
	typedef struct packed {
		logic push_chk;
		logic use_div;
		logic tgt_mod;
		logic glob;
		logic rd2;
	} class_t;

	typedef struct packed {
		op_t         op;
		class_t      cls;
		logic [31:0] operand;
		logic [7:0]  second_operand;
	} item_t;
endpackage
`default_nettype wire

/* hw/rtl/sme_ifs.sv */
// channel interfaces: instruction, result and configuration
`default_nettype none
interface sme_instr_if;
	logic               valid;
	logic               ready;
	logic [5:0]         kind;
	logic signed [31:0] operand;
	logic [7:0]         second_operand;
	modport source (output valid, kind, operand, second_operand, input ready);
	modport sink (input valid, kind, operand, second_operand, output ready);
endinterface

interface sme_result_if;
	logic               valid;
	logic               ready;
	logic [11:0]        next_address;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic               halted;
	logic [2:0]         status;
	modport source (output valid, next_address, print_valid, print_value, halted, status,
		input ready);
	modport sink (input valid, next_address, print_valid, print_value, halted, status,
		output ready);
endinterface

interface sme_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] stack_limit;
	modport source (output valid, stack_limit, input ready);
	modport sink (input valid, stack_limit, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sme_div.sv */
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none
module sme_div import sme_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quotient,
	output logic [WORD_W-1:0] remainder
);
	localparam int CW = $clog2(WORD_W + 1);

	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [WORD_W-1:0] quo_q, rem_q, den_q;
	logic [WORD_W:0]   trial, diff;

	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1)) && !start;
			if (start) begin
				cnt_q <= CW'(WORD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

/* hw/rtl/sme_front.sv */
// front end: takes instruction words, classifies them, two-entry queue
`default_nettype none
module sme_front import sme_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	sme_instr_if.sink instr,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);
	localparam int QD  = 2;
	localparam int QAW = $clog2(QD);
	localparam int QCW = $clog2(QD + 1);

	item_t          fifo_q [QD];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;
	item_t          dec;
	logic           push;

	always_comb begin
		dec.operand        = instr.operand;
		dec.second_operand = instr.second_operand;
		dec.op             = (instr.kind > KIND_LAST) ? OP_ILLEGAL : op_t'(instr.kind);
		dec.cls            = '0;
		unique case (dec.op) inside
			OP_PUSH, OP_DUP, OP_GET_LOCAL: dec.cls.push_chk = 1'b1;
			OP_GET_GLOBAL: begin
				dec.cls.push_chk = 1'b1;
				dec.cls.glob     = 1'b1;
			end
			OP_SET_GLOBAL: dec.cls.glob = 1'b1;
			OP_GET_PARAM: begin
				dec.cls.push_chk = 1'b1;
				dec.cls.rd2      = 1'b1;
			end
			OP_DIV, OP_MOD: dec.cls.use_div = 1'b1;
			OP_JUMP, OP_JUMP_POS, OP_JUMP_ZERO, OP_CALL: dec.cls.tgt_mod = 1'b1;
			OP_RET_VALUE, OP_RETURN: begin
				dec.cls.tgt_mod = 1'b1;
				dec.cls.rd2     = 1'b1;
			end
			default: dec.cls = '0;
		endcase
	end

	assign instr.ready = (cnt_q != QCW'(QD));
	assign push        = instr.valid && instr.ready;
	assign q_valid     = (cnt_q != '0);
	assign q_item      = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			if (push && !q_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= dec;
	end
endmodule
`default_nettype wire

/* hw/rtl/sme_back.sv */
// back end: stack and global memories, sequencer, divider and result register
`default_nettype none
module sme_back import sme_pkg::*; #(
	parameter int STACK_DEPTH  = 256,
	parameter int GLOBAL_DEPTH = 64,
	parameter int CODE_DEPTH   = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       q_pop,
	input  logic [7:0] stack_limit,
	sme_result_if.source result
);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int PW  = AW + 1;
	localparam int GAW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
	localparam int PCW = $clog2(CODE_DEPTH);
	localparam bit GD_POW2 = (GLOBAL_DEPTH == (1 << $clog2(GLOBAL_DEPTH)));
	localparam bit CD_POW2 = (CODE_DEPTH == (1 << $clog2(CODE_DEPTH)));
	localparam logic [31:0] GD_MASK = 32'(GLOBAL_DEPTH - 1);
	localparam logic [31:0] CD_MASK = 32'(CODE_DEPTH - 1);
	localparam logic [31:0] GD_WORD = 32'(GLOBAL_DEPTH);
	localparam logic [31:0] CD_WORD = 32'(CODE_DEPTH);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_RD1  = 9'b000000010,
		S_RD2  = 9'b000000100,
		S_PREP = 9'b000001000,
		S_DIV  = 9'b000010000,
		S_GRD  = 9'b000100000,
		S_EXE  = 9'b001000000,
		S_WR2  = 9'b010000000,
		S_WR3  = 9'b100000000
	} state_t;

	state_t         state_q;
	item_t          item_q;
	logic [PW-1:0]  sp_q, fp_q;
	logic [PCW-1:0] pc_q;
	logic           stopped_q;
	status_t        lstat_q;
	logic [31:0]    ra_q, rb_q, x_q, y_q, z_q, g_q, mres_q;
	logic [AW-1:0]  w2_addr_q, w3_addr_q;
	logic [31:0]    w2_data_q, w3_data_q;
	logic           has_w3_q;
	logic           ovalid_q, opv_q, ohalt_q;
	logic [11:0]    onext_q;
	logic [31:0]    opval_q;
	logic [2:0]     ostat_q;

	logic [31:0]    stack_mem [STACK_DEPTH];
	logic [31:0]    glob_mem [GLOBAL_DEPTH];

	logic [AW-1:0]  sp_a, fp_a, raddr_a, raddr_b, waddr;
	logic [31:0]    wdata;
	logic           we, gwe, slot_free, commit;

	logic           div_start, div_done;
	logic [31:0]    div_a, div_b, div_q, div_r, q_fix, r_fix;

	logic [31:0]    bin_res, push_val, ex_data, w2d_c, w3d_c, pval_c;
	logic [AW-1:0]  ex_addr, w2a_c, w3a_c;
	logic           ex_we, w2_c, w3_c, gwe_c, push_c, pv_c, blk, halt_c;
	logic [PW-1:0]  sp_n, fp_n;
	logic [PCW-1:0] pc_n, next_seq;
	status_t        status_c;
	logic [CHECK_W-1:0] sp_ext, limit_ext, save_sum;
	logic [31:0]    pc_wide;

	assign sp_a      = sp_q[AW-1:0];
	assign fp_a      = fp_q[AW-1:0];
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign slot_free = !ovalid_q || result.ready;
	assign commit    = (state_q == S_EXE) && slot_free;

	// read ports: queue head first, then param via first-pass data, or saved fp
	always_comb begin
		raddr_b = sp_a;
		if (state_q == S_IDLE) begin
			unique case (q_item.op) inside
				OP_GET_LOCAL: raddr_a = fp_a + AW'(HEADER_WORDS) + q_item.operand[AW-1:0];
				OP_GET_PARAM: raddr_a = fp_a + AW'(HDR_LOCALS);
				OP_RET_VALUE, OP_RETURN: raddr_a = fp_a;
				default: raddr_a = sp_a - 1'b1;
			endcase
		end else if (item_q.op == OP_GET_PARAM) begin
			raddr_a = fp_a + AW'(HEADER_WORDS) + ra_q[AW-1:0] + item_q.operand[AW-1:0];
		end else begin
			raddr_a = fp_a + AW'(HDR_SAVED_FP);
		end
	end

	// write port
	always_comb begin
		unique case (state_q)
			S_EXE: begin
				we    = commit && ex_we;
				waddr = ex_addr;
				wdata = ex_data;
			end
			S_WR2: begin
				we    = 1'b1;
				waddr = w2_addr_q;
				wdata = w2_data_q;
			end
			S_WR3: begin
				we    = 1'b1;
				waddr = w3_addr_q;
				wdata = w3_data_q;
			end
			default: begin
				we    = 1'b0;
				waddr = w2_addr_q;
				wdata = w2_data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) stack_mem[waddr] <= wdata;
		ra_q <= stack_mem[raddr_a];
		rb_q <= stack_mem[raddr_b];
	end

	assign gwe = commit && gwe_c;

	always_ff @(posedge clk) begin
		if (gwe) glob_mem[mres_q[GAW-1:0]] <= y_q;
		g_q <= glob_mem[mres_q[GAW-1:0]];
	end

	// divider operands and signed fix-up
	always_comb begin
		div_start = (state_q == S_PREP) && (
			(item_q.cls.use_div && (y_q != '0)) ||
			(item_q.cls.glob && !GD_POW2) ||
			(item_q.cls.tgt_mod && !CD_POW2));
		if (item_q.cls.use_div) begin
			div_a = x_q[31] ? (32'd0 - x_q) : x_q;
			div_b = y_q[31] ? (32'd0 - y_q) : y_q;
		end else if (item_q.cls.glob) begin
			div_a = item_q.operand;
			div_b = GD_WORD;
		end else begin
			div_a = (item_q.op == OP_RET_VALUE || item_q.op == OP_RETURN) ? x_q
				: item_q.operand;
			div_b = CD_WORD;
		end
		q_fix = (x_q[31] ^ y_q[31]) ? (32'd0 - div_q) : div_q;
		r_fix = x_q[31] ? (32'd0 - div_r) : div_r;
	end

	sme_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// two-operand ops: x is one below the top, y the top
	always_comb begin
		unique case (item_q.op)
			OP_ADD: bin_res = x_q + y_q;
			OP_SUB: bin_res = x_q - y_q;
			OP_MUL: bin_res = x_q * y_q;
			OP_AND: bin_res = 32'((x_q != '0) && (y_q != '0));
			OP_OR:  bin_res = 32'((x_q != '0) || (y_q != '0));
			OP_LT:  bin_res = 32'($signed(x_q) < $signed(y_q));
			OP_GT:  bin_res = 32'($signed(x_q) > $signed(y_q));
			OP_EQ:  bin_res = 32'(x_q == y_q);
			OP_LEQ: bin_res = 32'($signed(x_q) <= $signed(y_q));
			OP_GEQ: bin_res = 32'($signed(x_q) >= $signed(y_q));
			default: bin_res = 32'(x_q != y_q);
		endcase
	end

	// execute step
	always_comb begin
		sp_ext    = {{(CHECK_W - PW){sp_q[PW-1]}}, sp_q};
		limit_ext = {{(CHECK_W - 8){1'b0}}, stack_limit};
		save_sum  = CHECK_W'(HEADER_WORDS) + {{(CHECK_W - 32){item_q.operand[31]}},
			item_q.operand} + {{(CHECK_W - 8){1'b0}}, item_q.second_operand} + sp_ext;
		blk       = $signed(sp_ext) >= $signed(limit_ext);
		next_seq  = (pc_q == PCW'(CODE_DEPTH - 1)) ? '0 : pc_q + 1'b1;

		status_c = ST_RUN;
		ex_we    = 1'b0;
		ex_addr  = sp_a - 1'b1;
		ex_data  = bin_res;
		sp_n     = sp_q;
		fp_n     = fp_q;
		pc_n     = next_seq;
		pv_c     = 1'b0;
		pval_c   = '0;
		w2_c     = 1'b0;
		w3_c     = 1'b0;
		w2a_c    = sp_a;
		w2d_c    = x_q;
		w3a_c    = sp_a + AW'(2);
		w3d_c    = {{(32 - PW){fp_q[PW-1]}}, fp_q};
		gwe_c    = 1'b0;
		push_c   = 1'b0;
		push_val = item_q.operand;

		unique case (item_q.op) inside
			OP_HALT: status_c = ST_HALT;
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_LT, OP_GT, OP_EQ, OP_LEQ, OP_GEQ,
			OP_NEQ: begin
				ex_we = 1'b1;
				sp_n  = sp_q - 1'b1;
			end
			OP_DIV, OP_MOD: begin
				if (y_q == '0) begin
					status_c = ST_DIVZERO;
				end else begin
					ex_we   = 1'b1;
					ex_data = mres_q;
					sp_n    = sp_q - 1'b1;
				end
			end
			OP_NEG: begin
				ex_we   = 1'b1;
				ex_addr = sp_a;
				ex_data = 32'd0 - y_q;
			end
			OP_NOT: begin
				ex_we   = 1'b1;
				ex_addr = sp_a;
				ex_data = 32'(y_q == '0);
			end
			OP_PUSH: push_c = 1'b1;
			OP_POP: sp_n = sp_q - 1'b1;
			OP_SWAP: begin
				ex_we   = 1'b1;
				ex_data = y_q;
				w2_c    = 1'b1;
			end
			OP_DUP: begin
				push_c   = 1'b1;
				push_val = y_q;
			end
			OP_GET_GLOBAL: begin
				push_c   = 1'b1;
				push_val = g_q;
			end
			OP_SET_GLOBAL: begin
				gwe_c = 1'b1;
				sp_n  = sp_q - 1'b1;
			end
			OP_JUMP: pc_n = mres_q[PCW-1:0];
			OP_JUMP_POS: if ($signed(y_q) > 0) pc_n = mres_q[PCW-1:0];
			OP_JUMP_ZERO: if (y_q == '0) pc_n = mres_q[PCW-1:0];
			OP_GET_LOCAL: begin
				push_c   = 1'b1;
				push_val = x_q;
			end
			OP_SET_LOCAL: begin
				ex_we   = 1'b1;
				ex_addr = fp_a + AW'(HEADER_WORDS) + item_q.operand[AW-1:0];
				ex_data = y_q;
				sp_n    = sp_q - 1'b1;
			end
			OP_GET_PARAM: begin
				push_c   = 1'b1;
				push_val = z_q;
			end
			OP_SAVE: begin
				if ($signed(save_sum) >= $signed(limit_ext)) begin
					status_c = ST_FRAME;
				end else begin
					ex_we   = 1'b1;
					ex_addr = sp_a + AW'(HEADER_WORDS);
					ex_data = item_q.operand;
					w2_c    = 1'b1;
					w2a_c   = sp_a + AW'(HEADER_WORDS - 1);
					w2d_c   = 32'(item_q.second_operand);
					w3_c    = 1'b1;
					sp_n    = sp_q + PW'(HEADER_WORDS) + item_q.operand[PW-1:0];
				end
			end
			OP_FRAME: fp_n = sp_q - PW'(HEADER_WORDS) - item_q.operand[PW-1:0]
				- PW'(item_q.second_operand) + PW'(1);
			OP_CALL: begin
				ex_we   = 1'b1;
				ex_addr = fp_a;
				ex_data = 32'(next_seq);
				pc_n    = mres_q[PCW-1:0];
			end
			OP_RET_VALUE: begin
				ex_we   = 1'b1;
				ex_addr = fp_a + AW'(HDR_PARAMS);
				ex_data = y_q;
				w2_c    = 1'b1;
				w2a_c   = fp_a;
				w2d_c   = y_q;
				pc_n    = mres_q[PCW-1:0];
				sp_n    = fp_q;
				fp_n    = z_q[PW-1:0];
			end
			OP_RETURN: begin
				pc_n = mres_q[PCW-1:0];
				sp_n = fp_q - 1'b1;
				fp_n = z_q[PW-1:0];
			end
			OP_SAY: begin
				pv_c   = 1'b1;
				pval_c = y_q;
				sp_n   = sp_q - 1'b1;
			end
			default: status_c = ST_ILLEGAL;
		endcase

		if (push_c) begin
			if (blk) begin
				status_c = ST_OVERFLOW;
			end else begin
				ex_we   = 1'b1;
				ex_addr = sp_a + 1'b1;
				ex_data = push_val;
				sp_n    = sp_q + 1'b1;
			end
		end

		// any stop leaves every store and pointer alone
		if (status_c != ST_RUN || stopped_q) begin
			ex_we  = 1'b0;
			w2_c   = 1'b0;
			w3_c   = 1'b0;
			gwe_c  = 1'b0;
			pv_c   = 1'b0;
			pval_c = '0;
			sp_n   = sp_q;
			fp_n   = fp_q;
			pc_n   = pc_q;
		end
		halt_c  = stopped_q || (status_c != ST_RUN);
		pc_wide = 32'(pc_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '1;
			fp_q      <= '1;
			pc_q      <= '0;
			stopped_q <= 1'b0;
			lstat_q   <= ST_RUN;
			ovalid_q  <= 1'b0;
		end else begin
			if (commit) ovalid_q <= 1'b1;
			else if (result.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= stopped_q ? S_EXE : S_RD1;
				S_RD1: state_q <= item_q.cls.rd2 ? S_RD2 : S_PREP;
				S_RD2: state_q <= S_PREP;
				S_PREP: begin
					if (div_start) state_q <= S_DIV;
					else if (item_q.op == OP_GET_GLOBAL) state_q <= S_GRD;
					else state_q <= S_EXE;
				end
				S_DIV: begin
					if (div_done) state_q <= (item_q.op == OP_GET_GLOBAL) ? S_GRD : S_EXE;
				end
				S_GRD: state_q <= S_EXE;
				S_EXE: begin
					if (commit) begin
						state_q <= w2_c ? S_WR2 : S_IDLE;
						sp_q    <= sp_n;
						fp_q    <= fp_n;
						pc_q    <= pc_n;
						if (!stopped_q && status_c != ST_RUN) begin
							stopped_q <= 1'b1;
							lstat_q   <= status_c;
						end
					end
				end
				S_WR2: state_q <= has_w3_q ? S_WR3 : S_IDLE;
				S_WR3: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_item;
		if (state_q == S_RD1) begin
			x_q <= ra_q;
			y_q <= rb_q;
		end
		if (state_q == S_RD2) z_q <= ra_q;
		if (state_q == S_PREP) begin
			if (item_q.cls.glob) mres_q <= item_q.operand & GD_MASK;
			else if (item_q.op == OP_RET_VALUE || item_q.op == OP_RETURN)
				mres_q <= x_q & CD_MASK;
			else mres_q <= item_q.operand & CD_MASK;
		end
		if (state_q == S_DIV && div_done) begin
			if (item_q.op == OP_DIV) mres_q <= q_fix;
			else if (item_q.op == OP_MOD) mres_q <= r_fix;
			else mres_q <= div_r;
		end
		if (commit) begin
			w2_addr_q <= w2a_c;
			w2_data_q <= w2d_c;
			w3_addr_q <= w3a_c;
			w3_data_q <= w3d_c;
			has_w3_q  <= w3_c;
			onext_q   <= pc_wide[NEXT_W-1:0];
			opv_q     <= pv_c;
			opval_q   <= pval_c;
			ohalt_q   <= halt_c;
			ostat_q   <= stopped_q ? lstat_q : status_c;
		end
	end

	assign result.valid        = ovalid_q;
	assign result.next_address = onext_q;
	assign result.print_valid  = opv_q;
	assign result.print_value  = opval_q;
	assign result.halted       = ohalt_q;
	assign result.status       = ostat_q;
endmodule
`default_nettype wire

/* hw/rtl/stack_machine_execute_unit.sv */
// top level of the stack machine execute unit
// usage:
// - instr channel: one decoded instruction word per handshake (kind, operand,
//   second_operand); a two-entry queue in the front end takes words while the
//   back end is busy, so a stalled result blocks accepts only once the queue is full
// - result channel: exactly one result word per instruction, in order, with
//   the next fetch address, a printed value for say, halt flag and status
// - cfg channel: always ready; writes stack_limit; the user must write it only
//   while the unit is idle, the unit itself does not enforce this
// - the back-end sequencer takes one instruction at a time through registered
//   stack reads, execute and up to two extra stack writes for swap, save and
//   return with value; divide and modulo by a nonzero divisor, and target or global
//   index reduction by a non power of two depth also pass through the divider
// - reset: empty stack and no frame (pointers all ones), address zero, running,
//   stack_limit 20; stack and global stores are not cleared
// - a stalled receiver holds the result register; the back end finishes the
//   next instruction up to its execute step and waits there
// - after any stop every later instruction answers with the stopped address
`default_nettype none
module stack_machine_execute_unit import sme_pkg::*; #(
	parameter int STACK_DEPTH  = 256,
	parameter int GLOBAL_DEPTH = 64,
	parameter int CODE_DEPTH   = 4096
) (
	input  logic clk,
	input  logic arst_n,
	sme_instr_if.sink    instr,
	sme_result_if.source result,
	sme_cfg_if.sink      cfg
);
	logic       q_valid, q_pop;
	item_t      q_item;
	logic [7:0] limit_q;

	// stack limit register, written through the cfg channel
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.stack_limit;
		end
	end

	// front end: accept and classify, queue toward the back end
	sme_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.instr   (instr),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// back end: executes one queued instruction at a time
	sme_back #(
		.STACK_DEPTH  (STACK_DEPTH),
		.GLOBAL_DEPTH (GLOBAL_DEPTH),
		.CODE_DEPTH   (CODE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.stack_limit (limit_q),
		.result      (result)
	);
endmodule
`default_nettype wire

/* hw/rtl/sme_checker.sv */
// port-level checker for the stack machine execute unit, bound to the top
`default_nettype none
`include "stack_machine_execute_unit_defines.svh"
module sme_checker import sme_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [11:0] res_next_address,
	input logic        res_print_valid,
	input logic [31:0] res_print_value,
	input logic        res_halted,
	input logic [2:0]  res_status
);
	logic        halt_seen_q;
	logic [11:0] halt_addr_q;
	logic [2:0]  halt_stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_seen_q <= 1'b0;
		end else if (res_valid && res_ready && res_halted) begin
			halt_seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready && res_halted && !halt_seen_q) begin
			halt_addr_q <= res_next_address;
			halt_stat_q <= res_status;
		end
	end

	`SME_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable(res_next_address) && $stable(res_print_value), "result word changed while stalled")
	`SME_ASSERT_IMPL(a_status, res_valid, (res_status != ST_RUN) == res_halted, "status and halt flag disagree")
	`SME_ASSERT_IMPL(a_no_print, res_valid && res_halted, !res_print_valid, "print on a stopped result")
	`SME_ASSERT_IMPL(a_print_zero, res_valid && !res_print_valid, res_print_value == 32'd0, "print value not zero without print")
	`SME_ASSERT_IMPL(a_sticky, res_valid && halt_seen_q, res_halted && (res_next_address == halt_addr_q) && (res_status == halt_stat_q), "stopped machine changed its answer")
endmodule

bind stack_machine_execute_unit sme_checker u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.res_next_address (result.next_address),
	.res_print_valid  (result.print_valid),
	.res_print_value  (result.print_value),
	.res_halted       (result.halted),
	.res_status       (result.status)
);
`default_nettype wire

/* dv/testbench.sv */
// self-checking testbench for the stack machine execute unit
`timescale 1ns/1ps
`default_nettype none
module testbench;
	import sme_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// one decoded instruction word as driven on the instr channel
	typedef struct {
		logic [5:0]  kind;
		logic [31:0] operand;
		logic [7:0]  second_operand;
	} instr_word_t;

	// one answer word as seen on the result channel
	typedef struct {
		logic [11:0] next_address;
		logic        print_valid;
		logic [31:0] print_value;
		logic        halted;
		logic [2:0]  status;
	} answer_t;

	// architectural state of the machine, kept twice: once for planning, once for checking
	typedef struct {
		logic [31:0]       stack_mem [256];
		logic [31:0]       global_mem [64];
		logic signed [8:0] sp;
		logic signed [8:0] fp;
		logic [11:0]       pc;
		logic              stopped;
		status_t           latched;
		logic [7:0]        limit;
	} machine_t;

	localparam int HOLD_OFF_START  = 4000;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int CYCLE_LIMIT     = 2000000;
	localparam int RANDOM_ITEMS    = 850;

	logic clk;
	logic arst_n;

	sme_instr_if  instr ();
	sme_result_if result ();
	sme_cfg_if    cfg ();

	stack_machine_execute_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr),
		.result (result),
		.cfg    (cfg)
	);

	machine_t    plan_state;     // state as the stimulus generator sees it ahead of time
	machine_t    golden_state;   // state advanced at each accepted word
	instr_word_t pending_words[$];
	answer_t     expected_answers[$];
	logic        quiet;          // no random idling on either side
	logic        hold_off;       // receiver long stall
	int          cycle_count;
	int          mismatches;
	int          answers_seen;
	int          prints_seen;
	int          calls_planned;
	int          words_planned;

	// ---------------------------------------------------------------------
	// predictor: executes one instruction on a machine state
	// ---------------------------------------------------------------------
	function automatic logic signed [8:0] wrap9(input int v);
		return v[8:0];
	endfunction

	function automatic logic [31:0] rd_slot(input machine_t m, input int a);
		return m.stack_mem[a[7:0]];
	endfunction

	function automatic answer_t execute_word(inout machine_t m, input instr_word_t w);
		answer_t     ans;
		status_t     st;
		logic [11:0] nxt;
		int          sp_i, fp_i, op_i, locals_i;
		longint      chk;
		logic [31:0] a, b, v, rv;
		ans = '{default: '0};
		if (m.stopped) begin
			ans.next_address = m.pc;
			ans.halted = 1'b1;
			ans.status = m.latched;
			return ans;
		end
		st = ST_RUN;
		nxt = m.pc + 12'd1;
		sp_i = int'(m.sp);
		fp_i = int'(m.fp);
		op_i = int'($signed(w.operand));
		a = rd_slot(m, sp_i - 1);
		b = rd_slot(m, sp_i);
		case (w.kind)
			OP_HALT: st = ST_HALT;
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_LT, OP_GT, OP_EQ, OP_LEQ, OP_GEQ,
			OP_NEQ, OP_DIV, OP_MOD: begin
				if ((w.kind == OP_DIV || w.kind == OP_MOD) && b == 32'd0) begin
					st = ST_DIVZERO;
				end else begin
					case (w.kind)
						OP_ADD: v = a + b;
						OP_SUB: v = a - b;
						OP_MUL: v = a * b;
						// 64-bit divide so the most negative word over minus one wraps to itself
						OP_DIV: v = 32'(longint'($signed(a)) / longint'($signed(b)));
						OP_MOD: v = 32'(longint'($signed(a)) % longint'($signed(b)));
						OP_AND: v = {31'd0, a != 0 && b != 0};
						OP_OR:  v = {31'd0, a != 0 || b != 0};
						OP_LT:  v = {31'd0, $signed(a) < $signed(b)};
						OP_GT:  v = {31'd0, $signed(a) > $signed(b)};
						OP_EQ:  v = {31'd0, a == b};
						OP_LEQ: v = {31'd0, $signed(a) <= $signed(b)};
						OP_GEQ: v = {31'd0, $signed(a) >= $signed(b)};
						default: v = {31'd0, a != b};
					endcase
					m.stack_mem[8'(sp_i - 1)] = v;
					m.sp = wrap9(sp_i - 1);
				end
			end
			OP_NEG: m.stack_mem[8'(sp_i)] = 32'd0 - b;
			OP_NOT: m.stack_mem[8'(sp_i)] = {31'd0, b == 0};
			OP_POP: m.sp = wrap9(sp_i - 1);
			OP_SWAP: begin
				m.stack_mem[8'(sp_i - 1)] = b;
				m.stack_mem[8'(sp_i)] = a;
			end
			OP_PUSH, OP_DUP, OP_GET_GLOBAL, OP_GET_LOCAL, OP_GET_PARAM: begin
				if (int'(m.sp) >= int'(m.limit)) begin
					st = ST_OVERFLOW;
				end else begin
					case (w.kind)
						OP_PUSH:       v = w.operand;
						OP_DUP:        v = b;
						OP_GET_GLOBAL: v = m.global_mem[w.operand[5:0]];
						OP_GET_LOCAL:  v = rd_slot(m, fp_i + HEADER_WORDS + op_i);
						default: begin
							locals_i = int'($signed(rd_slot(m, fp_i + HDR_LOCALS)));
							v = rd_slot(m, fp_i + HEADER_WORDS + locals_i + op_i);
						end
					endcase
					m.sp = wrap9(sp_i + 1);
					m.stack_mem[8'(sp_i + 1)] = v;
				end
			end
			OP_SET_GLOBAL: begin
				m.global_mem[w.operand[5:0]] = b;
				m.sp = wrap9(sp_i - 1);
			end
			OP_JUMP: nxt = w.operand[11:0];
			OP_JUMP_POS: if ($signed(b) > 0) nxt = w.operand[11:0];
			OP_JUMP_ZERO: if (b == 0) nxt = w.operand[11:0];
			OP_SET_LOCAL: begin
				m.stack_mem[8'(fp_i + HEADER_WORDS + op_i)] = b;
				m.sp = wrap9(sp_i - 1);
			end
			OP_SAVE: begin
				chk = longint'(HEADER_WORDS) + longint'(op_i) + longint'(w.second_operand)
					+ longint'(sp_i);
				if (chk >= longint'(m.limit)) begin
					st = ST_FRAME;
				end else begin
					sp_i = sp_i + HEADER_WORDS;
					m.stack_mem[8'(sp_i)] = w.operand;
					m.stack_mem[8'(sp_i - 1)] = {24'd0, w.second_operand};
					m.stack_mem[8'(sp_i - 2)] = {{23{m.fp[8]}}, m.fp};
					m.sp = wrap9(sp_i + op_i);
				end
			end
			OP_FRAME: m.fp = wrap9(sp_i - (HEADER_WORDS + op_i + int'(w.second_operand)) + 1);
			OP_CALL: begin
				m.stack_mem[8'(fp_i)] = {20'd0, nxt};
				nxt = w.operand[11:0];
			end
			OP_RET_VALUE: begin
				nxt = rd_slot(m, fp_i) & 32'hfff;
				m.stack_mem[8'(fp_i + HDR_PARAMS)] = b;
				m.stack_mem[8'(fp_i)] = b;
				m.sp = wrap9(fp_i);
				rv = rd_slot(m, fp_i + HDR_SAVED_FP);
				m.fp = rv[8:0];
			end
			OP_RETURN: begin
				nxt = rd_slot(m, fp_i) & 32'hfff;
				m.sp = wrap9(fp_i - 1);
				rv = rd_slot(m, fp_i + HDR_SAVED_FP);
				m.fp = rv[8:0];
			end
			OP_SAY: begin
				ans.print_valid = 1'b1;
				ans.print_value = b;
				m.sp = wrap9(sp_i - 1);
			end
			default: st = ST_ILLEGAL;
		endcase
		if (st != ST_RUN) begin
			m.stopped = 1'b1;
			m.latched = st;
			nxt = m.pc;
		end
		m.pc = nxt;
		ans.next_address = nxt;
		ans.halted = m.stopped;
		ans.status = st;
		return ans;
	endfunction

	function automatic machine_t machine_at_reset();
		machine_t m;
		foreach (m.stack_mem[i]) m.stack_mem[i] = '0;
		foreach (m.global_mem[i]) m.global_mem[i] = '0;
		m.sp = -9'sd1;
		m.fp = -9'sd1;
		m.pc = '0;
		m.stopped = 1'b0;
		m.latched = ST_RUN;
		m.limit = LIMIT_RESET;
		return m;
	endfunction

	// ---------------------------------------------------------------------
	// clock, reset, cycle limit
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, expected_answers.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// instruction driver: feeds pending words, predicts at each accept
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instr.valid <= 1'b0;
			instr.kind <= '0;
			instr.operand <= '0;
			instr.second_operand <= '0;
		end else begin
			if (instr.valid && instr.ready) begin
				// word taken: advance the golden machine and queue its answer
				expected_answers.push_back(execute_word(golden_state, pending_words[0]));
				void'(pending_words.pop_front());
			end
			if (instr.valid && !instr.ready) begin
				// offer stands until the unit takes it
			end else if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
				instr.valid <= 1'b1;
				instr.kind <= pending_words[0].kind;
				instr.operand <= pending_words[0].operand;
				instr.second_operand <= pending_words[0].second_operand;
			end else begin
				instr.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// result monitor: random back-pressure, compares each word in order
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				answers_seen <= answers_seen + 1;
				if (result.print_valid) prints_seen <= prints_seen + 1;
				if (expected_answers.size() == 0) begin
					$display("%0t: result word with nothing expected, next_address %0d",
						$time, result.next_address);
					mismatches <= mismatches + 1;
				end else begin
					if (result.next_address !== expected_answers[0].next_address
						|| result.print_valid !== expected_answers[0].print_valid
						|| result.print_value !== expected_answers[0].print_value
						|| result.halted !== expected_answers[0].halted
						|| result.status !== expected_answers[0].status) begin
						$display("%0t: expected addr %0d print %0b/%h halted %0b status %0d",
							$time, expected_answers[0].next_address,
							expected_answers[0].print_valid, expected_answers[0].print_value,
							expected_answers[0].halted, expected_answers[0].status);
						$display("%0t:   actual addr %0d print %0b/%h halted %0b status %0d",
							$time, result.next_address, result.print_valid,
							result.print_value, result.halted, result.status);
						mismatches <= mismatches + 1;
					end
					void'(expected_answers.pop_front());
				end
			end
			result.ready <= !hold_off && (quiet || $urandom_range(99) >= 16);
		end
	end

	// long receiver stall while the sender keeps offering, so the front end fills
	initial begin
		hold_off = 1'b0;
		repeat (HOLD_OFF_START) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ---------------------------------------------------------------------
	// stimulus planning
	// ---------------------------------------------------------------------
	// queue a word only if the planned machine keeps running with it
	function automatic bit plan_word(input logic [5:0] kind, input logic [31:0] operand,
		input logic [7:0] second_operand);
		machine_t    trial;
		instr_word_t w;
		answer_t     ans;
		w = '{kind, operand, second_operand};
		trial = plan_state;
		ans = execute_word(trial, w);
		if (trial.stopped) return 1'b0;
		plan_state = trial;
		pending_words.push_back(w);
		words_planned++;
		return 1'b1;
	endfunction

	function automatic logic [31:0] random_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'hffff_ffff;
			2: return 32'd0;
			3: return $urandom_range(9);
			default: return $urandom;
		endcase
	endfunction

	// one well-formed call: parameters, save, frame, call, body, return
	function automatic void plan_call();
		int          nparams, nlocals, nbody;
		logic [5:0]  body_kind;
		nparams = $urandom_range(3);
		nlocals = $urandom_range(3);
		for (int i = 0; i < nparams; i++) void'(plan_word(OP_PUSH, random_value(), $urandom));
		if (!plan_word(OP_SAVE, nlocals, nparams)) return;
		void'(plan_word(OP_FRAME, nlocals, nparams));
		void'(plan_word(OP_CALL, $urandom, $urandom));
		calls_planned++;
		nbody = $urandom_range(4);
		for (int i = 0; i < nbody; i++) begin
			case ($urandom_range(3))
				0: body_kind = OP_GET_LOCAL;
				1: body_kind = OP_SET_LOCAL;
				2: body_kind = OP_GET_PARAM;
				default: body_kind = OP_ADD;
			endcase
			void'(plan_word(body_kind, $urandom_range(3), $urandom));
		end
		if ($urandom_range(1)) void'(plan_word(OP_RET_VALUE, $urandom, $urandom));
		else void'(plan_word(OP_RETURN, $urandom, $urandom));
	endfunction

	// any running instruction with a random operand shaped to the op
	function automatic bit plan_random();
		logic [5:0]  kind;
		logic [31:0] operand;
		kind = $urandom_range(OP_ADD, OP_SAY);
		case (kind)
			OP_GET_LOCAL, OP_SET_LOCAL, OP_GET_PARAM:
				operand = $urandom_range(3) == 0 ? $urandom : $urandom_range(5);
			OP_SAVE, OP_FRAME: operand = $urandom_range(3);
			default: operand = random_value();
		endcase
		return plan_word(kind, operand,
			(kind == OP_SAVE || kind == OP_FRAME) ? $urandom_range(3) : $urandom);
	endfunction

	task automatic drain_then_idle();
		while (pending_words.size() > 0 || expected_answers.size() > 0) @(posedge clk);
		// every word answers, so a short margin covers the pipeline
		repeat (20) @(posedge clk);
	endtask

	task automatic write_stack_limit(input logic [7:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.stack_limit <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		plan_state.limit = value;
		golden_state.limit = value;
	endtask

	// ---------------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------------
	initial begin
		logic [7:0] limits [5];
		int         accepted_random;
		int         stop_pick;
		int         guard;
		limits = '{8'd0, 8'd8, 8'd40, 8'd128, 8'd255};
		cfg.valid = 1'b0;
		cfg.stack_limit = '0;
		quiet = 1'b0;
		cycle_count = 0;
		mismatches = 0;
		answers_seen = 0;
		prints_seen = 0;
		calls_planned = 0;
		words_planned = 0;
		plan_state = machine_at_reset();
		golden_state = machine_at_reset();
		@(posedge arst_n);

		// fill every stack slot and every global once so no later read sees an unwritten entry
		write_stack_limit(8'd255);
		for (int i = 0; i < 256; i++) void'(plan_word(OP_PUSH, $urandom, $urandom));
		for (int i = 0; i < 64; i++) void'(plan_word(OP_SET_GLOBAL, i, $urandom));
		for (int i = 0; i < 192; i++) void'(plan_word(OP_POP, $urandom, $urandom));
		drain_then_idle();

		// directed: word extremes, divide corner cases, a selection of ops and two calls
		write_stack_limit(8'd40);
		void'(plan_word(OP_PUSH, 32'h8000_0000, 8'hff));
		void'(plan_word(OP_PUSH, 32'hffff_ffff, 8'h00));
		void'(plan_word(OP_DIV, 32'd0, 8'd0));
		void'(plan_word(OP_SAY, 32'd0, 8'd0));
		void'(plan_word(OP_PUSH, 32'h8000_0000, 8'd0));
		void'(plan_word(OP_PUSH, 32'hffff_ffff, 8'd0));
		void'(plan_word(OP_MOD, 32'd0, 8'd0));
		void'(plan_word(OP_PUSH, 32'h7fff_ffff, 8'd0));
		void'(plan_word(OP_PUSH, -32'sd7, 8'd0));
		void'(plan_word(OP_MOD, 32'd0, 8'd0));
		void'(plan_word(OP_NEG, 32'd0, 8'd0));
		void'(plan_word(OP_NOT, 32'd0, 8'd0));
		void'(plan_word(OP_DUP, 32'd0, 8'd0));
		void'(plan_word(OP_SWAP, 32'd0, 8'd0));
		void'(plan_word(OP_GET_GLOBAL, 32'hffff_ffff, 8'd0));
		void'(plan_word(OP_SET_GLOBAL, 32'h8000_0000, 8'd0));
		void'(plan_word(OP_JUMP, 32'hffff_ffff, 8'd0));
		void'(plan_word(OP_JUMP_POS, 32'h0000_0fff, 8'd0));
		void'(plan_word(OP_JUMP_ZERO, 32'd5, 8'd0));
		plan_call();
		plan_call();
		drain_then_idle();

		// random phases across several stack limits, one phase without idling
		accepted_random = 0;
		foreach (limits[p]) begin
			write_stack_limit(limits[p]);
			quiet = (p == 2);
			guard = 0;
			while (accepted_random < (p + 1) * RANDOM_ITEMS / 5 && guard < 20000) begin
				guard++;
				if ($urandom_range(4) == 0) begin
					plan_call();
					accepted_random++;
				end else if (plan_random()) begin
					accepted_random++;
				end
				// keep the planner from running far ahead of the driver
				while (pending_words.size() > 64) @(posedge clk);
			end
			drain_then_idle();
		end
		quiet = 1'b0;

		// one stop per run: it latches until reset, so it comes last
		stop_pick = $urandom_range(4);
		guard = 0;
		while (!plan_state.stopped && guard < 300) begin
			instr_word_t w;
			answer_t     ans;
			guard++;
			case (stop_pick)
				0: w = '{OP_HALT, $urandom, $urandom};
				1: w = '{6'($urandom_range(KIND_LAST + 1, 63)), $urandom, $urandom};
				2: w = '{OP_PUSH, $urandom, $urandom};
				3: w = guard == 1 ? '{OP_PUSH, 32'd0, 8'd0} : '{OP_DIV, 32'd0, 8'd0};
				default: w = '{OP_SAVE, 32'h7fff_ffff, 8'hff};
			endcase
			ans = execute_word(plan_state, w);
			pending_words.push_back(w);
		end
		// words after the stop are ignored and answer with the stopped address
		for (int i = 0; i < 6; i++) begin
			instr_word_t w;
			answer_t     ans;
			w = '{6'($urandom), $urandom, $urandom};
			ans = execute_word(plan_state, w);
			pending_words.push_back(w);
		end
		drain_then_idle();

		$display("ran %0d instruction words (%0d planned calls), %0d answers, %0d prints",
			answers_seen, calls_planned, answers_seen, prints_seen);
		$display("stack limits 0 to 255 visited, final stop status %0d", golden_state.latched);
		if (mismatches == 0 && expected_answers.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* stack_machine_execute_unit.f */
+incdir+hw/rtl
hw/rtl/sme_pkg.sv
hw/rtl/sme_ifs.sv
hw/rtl/sme_div.sv
hw/rtl/sme_front.sv
hw/rtl/sme_back.sv
hw/rtl/stack_machine_execute_unit.sv
hw/rtl/sme_checker.sv
dv/testbench.sv
